[src/dtmfenc_pkg.sv]
// Package: shared types, constants and key decoding for the DTMF event payload encoder.
`default_nettype none

package dtmfenc_pkg;

    // Only the low 14 bits of a timestamp ever reach the payload.
    localparam int OFFSET_W = 14;

    localparam logic [9:0] BLOCK_LEN = 10'd4;

    localparam logic [7:0] KEY_0      = 8'h30;
    localparam logic [7:0] KEY_9      = 8'h39;
    localparam logic [7:0] KEY_STAR   = 8'h2A;
    localparam logic [7:0] KEY_HASH   = 8'h23;
    localparam logic [7:0] KEY_UP_A   = 8'h41;
    localparam logic [7:0] KEY_UP_B   = 8'h42;
    localparam logic [7:0] KEY_UP_C   = 8'h43;
    localparam logic [7:0] KEY_UP_D   = 8'h44;
    localparam logic [7:0] KEY_LO_A   = 8'h61;
    localparam logic [7:0] KEY_LO_B   = 8'h62;
    localparam logic [7:0] KEY_LO_C   = 8'h63;
    localparam logic [7:0] KEY_LO_D   = 8'h64;

    localparam logic [7:0] CODE_STAR    = 8'd10;
    localparam logic [7:0] CODE_HASH    = 8'd11;
    localparam logic [7:0] CODE_A       = 8'd12;
    localparam logic [7:0] CODE_B       = 8'd13;
    localparam logic [7:0] CODE_C       = 8'd14;
    localparam logic [7:0] CODE_D       = 8'd15;
    localparam logic [7:0] CODE_UNKNOWN = 8'd255;

    // Configuration register indexes
    localparam logic [7:0] REG_MODE = 8'd0;
    localparam logic [7:0] REG_PT   = 8'd1;

    typedef struct packed {
        logic [7:0]          code;
        logic [5:0]          volume;
        logic [15:0]         duration;
        logic [OFFSET_W-1:0] stamp;
    } hist_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_HDR  = 4'b0010,
        ST_PT   = 4'b0100,
        ST_BLK  = 4'b1000
    } seq_state_t;

    function automatic logic [7:0] key_to_code(input logic [7:0] c);
        logic [7:0] code;
        code = CODE_UNKNOWN;
        priority if (c >= KEY_0 && c <= KEY_9)
            code = c - KEY_0;
        else if (c == KEY_STAR)
            code = CODE_STAR;
        else if (c == KEY_HASH)
            code = CODE_HASH;
        else if (c == KEY_UP_A || c == KEY_LO_A)
            code = CODE_A;
        else if (c == KEY_UP_B || c == KEY_LO_B)
            code = CODE_B;
        else if (c == KEY_UP_C || c == KEY_LO_C)
            code = CODE_C;
        else if (c == KEY_UP_D || c == KEY_LO_D)
            code = CODE_D;
        else
            code = CODE_UNKNOWN;
        return code;
    endfunction

endpackage

`default_nettype wire

[src/dtmf_event_payload_encoder.sv]
// Top level: DTMF event payload encoder, byte-serial output under a small sequencer.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+-------------------------------------------
//  in       | in  | in_tvalid / in_tready   | in_tdata: key, end, volume, duration, stamp
//  out      | out | out_tvalid / out_tready | out_tdata: payload byte, out_tlast: final
//  cfg      | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One byte per cycle from one shared word/byte unit: plain mode 4 bytes, redundant
// mode 8*n-3 bytes for n stored events (21 at depth 3).
// in_tready is high only while the sequencer is idle; out_tready low with a byte pending freezes it.
// Reset clears the history count, configuration and the sequencer; cfg_ready is always high.
`default_nettype none

module dtmf_event_payload_encoder #(
    parameter int HISTORY_DEPTH = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_tvalid,
    output logic             in_tready,
    // [7:0] key_char, [8] end_flag, [14:9] volume, [30:15] duration, [62:31] timestamp
    input  wire logic [63:0] in_tdata,
    output logic             out_tvalid,
    input  wire logic        out_tready,
    // [7:0] out_byte
    output logic [7:0]       out_tdata,
    output logic             out_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import dtmfenc_pkg::*;

    localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    logic                 mode_reg;
    logic [6:0]           pt_reg;

    seq_state_t           state_reg, state_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [IW-1:0]        last_idx_reg, last_idx_next;
    logic [1:0]           byte_reg, byte_next;
    logic                 plain_reg, plain_next;
    logic                 end_reg, end_next;
    logic [OFFSET_W-1:0]  newest_reg, newest_next;

    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;

    logic                 in_xfer;
    logic                 adv;
    hist_entry_t          push_entry;
    hist_entry_t          rd_entry;
    logic [CW-1:0]        count;
    logic                 full;
    logic [IW-1:0]        load_last_idx;
    logic [OFFSET_W-1:0]  offset;
    logic                 ebit;
    logic [31:0]          word;
    logic [7:0]           byte_sel;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= 1'b0;
            pt_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_MODE)
                mode_reg <= cfg_data[0];
            else if (cfg_index == REG_PT)
                pt_reg <= cfg_data[6:0];
        end
    end

    assign in_tready = (state_reg == ST_IDLE);
    assign in_xfer   = in_tvalid && in_tready;

    assign push_entry.code     = key_to_code(in_tdata[7:0]);
    assign push_entry.volume   = in_tdata[14:9];
    assign push_entry.duration = in_tdata[30:15];
    assign push_entry.stamp    = in_tdata[31 +: OFFSET_W];

    dtmfenc_hist #(
        .DEPTH (HISTORY_DEPTH),
        .IW    (IW),
        .CW    (CW)
    ) u_hist (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_xfer),
        .push_entry (push_entry),
        .rd_idx     (idx_reg),
        .rd_entry   (rd_entry),
        .count      (count)
    );

    assign full          = (count == CW'(HISTORY_DEPTH));
    assign load_last_idx = full ? IW'(HISTORY_DEPTH - 1) : IW'(count);

    // Shared word unit: header or event block of the entry under idx_reg.
    assign offset = newest_reg - rd_entry.stamp;
    assign ebit   = plain_reg ? end_reg : (idx_reg != last_idx_reg);

    always_comb
    begin
        if (state_reg == ST_HDR)
            word = {1'b1, pt_reg, offset, BLOCK_LEN};
        else
            word = {rd_entry.code, ebit, 1'b0, rd_entry.volume, rd_entry.duration};
    end

    always_comb
    begin
        unique case (byte_reg)
            2'd0:    byte_sel = word[31:24];
            2'd1:    byte_sel = word[23:16];
            2'd2:    byte_sel = word[15:8];
            2'd3:    byte_sel = word[7:0];
            default: byte_sel = word[7:0];
        endcase
    end

    // Sequencer moves only when the output register is free or being drained.
    assign adv = !out_valid_reg || out_tready;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        byte_next      = byte_reg;
        plain_next     = plain_reg;
        end_next       = end_reg;
        newest_next    = newest_reg;
        out_valid_next = out_valid_reg && !out_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer) begin
                    plain_next    = !mode_reg;
                    end_next      = in_tdata[8];
                    newest_next   = push_entry.stamp;
                    last_idx_next = load_last_idx;
                    byte_next     = 2'd0;
                    if (!mode_reg) begin
                        state_next = ST_BLK;
                        idx_next   = load_last_idx;
                    end else begin
                        idx_next   = '0;
                        state_next = (load_last_idx != '0) ? ST_HDR : ST_PT;
                    end
                end
            end
            ST_HDR:
            begin
                if (adv) begin
                    out_valid_next = 1'b1;
                    out_data_next  = byte_sel;
                    out_last_next  = 1'b0;
                    byte_next      = byte_reg + 2'd1;
                    if (byte_reg == 2'd3) begin
                        if (idx_reg + 1'b1 == last_idx_reg)
                            state_next = ST_PT;
                        else
                            idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_PT:
            begin
                if (adv) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, pt_reg};
                    out_last_next  = 1'b0;
                    idx_next       = '0;
                    byte_next      = 2'd0;
                    state_next     = ST_BLK;
                end
            end
            ST_BLK:
            begin
                if (adv) begin
                    out_valid_next = 1'b1;
                    out_data_next  = byte_sel;
                    out_last_next  = (byte_reg == 2'd3) && (idx_reg == last_idx_reg);
                    byte_next      = byte_reg + 2'd1;
                    if (byte_reg == 2'd3) begin
                        if (idx_reg == last_idx_reg)
                            state_next = ST_IDLE;
                        else
                            idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            last_idx_reg  <= '0;
            byte_reg      <= '0;
            plain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            last_idx_reg  <= last_idx_next;
            byte_reg      <= byte_next;
            plain_reg     <= plain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg      <= end_next;
        newest_reg   <= newest_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = out_data_reg;
    assign out_tlast  = out_last_reg;

endmodule

`default_nettype wire

[src/dtmfenc_hist.sv]
// Event history: the last DEPTH events, oldest at index 0, with a fill count.
`default_nettype none

module dtmfenc_hist #(
    parameter int DEPTH = 3,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire dtmfenc_pkg::hist_entry_t  push_entry,
    input  wire logic [IW-1:0]             rd_idx,
    output dtmfenc_pkg::hist_entry_t       rd_entry,
    output logic [CW-1:0]                  count
);
    import dtmfenc_pkg::*;

    hist_entry_t     entry_reg [DEPTH];
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            full;

    assign full = (count_reg == CW'(DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !full)
            count_next = count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // When full, everything moves down one place and the new event lands on top.
    for (genvar i = 0; i < DEPTH; i++) begin : g_entry
        if (i < DEPTH - 1) begin : g_shift
            always_ff @(posedge clk)
            begin
                if (push) begin
                    if (full)
                        entry_reg[i] <= entry_reg[i + 1];
                    else if (count_reg == CW'(i))
                        entry_reg[i] <= push_entry;
                end
            end
        end else begin : g_top
            always_ff @(posedge clk)
            begin
                if (push && (full || count_reg == CW'(i)))
                    entry_reg[i] <= push_entry;
            end
        end
    end

    assign rd_entry = entry_reg[rd_idx];
    assign count    = count_reg;

endmodule

`default_nettype wire

[src/dtmfenc_checker.sv]
// Port-level checker for the DTMF event payload encoder, bound to the top level.
`default_nettype none

module dtmfenc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_tvalid,
    input wire logic       in_tready,
    input wire logic       out_tvalid,
    input wire logic       out_tready,
    input wire logic [7:0] out_tdata,
    input wire logic       out_tlast
);

    // A stalled output transfer keeps its byte and last flag.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)
                                         && $stable(out_tlast)))
        else $error("output changed while stalled");

    // Only one event in flight: a taken item closes the input until its last byte is registered.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_tvalid && in_tready) |=> !in_tready)
        else $error("input open right after a transfer");

    // No bubble inside a payload.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
        else $error("gap inside payload");

endmodule

bind dtmf_event_payload_encoder dtmfenc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
);

`default_nettype wire

[dv/dtmf_payload_checker.sv]
// Checker: watches the event, byte and register channels, predicts payload bytes, compares.
`timescale 1ns / 100ps

module dtmf_payload_checker #(
    parameter int DEPTH = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_tvalid,
    input  wire logic        in_tready,
    input  wire logic [63:0] in_tdata,
    input  wire logic        out_tvalid,
    input  wire logic        out_tready,
    input  wire logic [7:0]  out_tdata,
    input  wire logic        out_tlast,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    output int               mismatches,
    output int               outstanding
);
    import dtmfenc_pkg::*;

    typedef struct packed {
        logic [7:0]  code;
        logic [5:0]  volume;
        logic [15:0] duration;
        logic [31:0] stamp;
    } key_event_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } payload_byte_t;

    payload_byte_t payload_q[$];
    key_event_t    events[DEPTH];
    int            n_events;
    int            err_cnt = 0;
    logic          redundant;
    logic [6:0]    block_pt;

    function automatic logic [7:0] event_code(input logic [7:0] c);
        if (c >= KEY_0 && c <= KEY_9)
            return c - KEY_0;
        case (c)
            KEY_STAR:           return CODE_STAR;
            KEY_HASH:           return CODE_HASH;
            KEY_UP_A, KEY_LO_A: return CODE_A;
            KEY_UP_B, KEY_LO_B: return CODE_B;
            KEY_UP_C, KEY_LO_C: return CODE_C;
            KEY_UP_D, KEY_LO_D: return CODE_D;
            default:            return CODE_UNKNOWN;
        endcase
    endfunction

    // One 32-bit word goes out MSB first.
    task automatic push_word(input logic [31:0] w, input logic last);
        payload_byte_t b;
        for (int k = 0; k < 4; k++)
        begin
            b.data = w[31 - 8 * k -: 8];
            b.last = last && (k == 3);
            payload_q.push_back(b);
        end
    endtask

    task automatic encode_event(input logic [63:0] d);
        key_event_t    ev;
        payload_byte_t pt_byte;
        logic          end_bit;
        logic [31:0]   diff;
        int            n;
        ev.code     = event_code(d[7:0]);
        end_bit     = d[8];
        ev.volume   = d[14:9];
        ev.duration = d[30:15];
        ev.stamp    = d[62:31];

        // History full: drop the oldest entry.
        if (n_events == DEPTH)
        begin
            for (int i = 1; i < DEPTH; i++)
                events[i - 1] = events[i];
            n_events = DEPTH - 1;
        end
        events[n_events] = ev;
        n_events++;

        if (!redundant)
        begin
            push_word({ev.code, end_bit, 1'b0, ev.volume, ev.duration}, 1'b1);
        end
        else
        begin
            n = n_events;
            for (int i = 0; i < n - 1; i++)
            begin
                diff = events[n - 1].stamp - events[i].stamp;
                push_word({1'b1, block_pt, diff[OFFSET_W-1:0], BLOCK_LEN}, 1'b0);
            end
            pt_byte.data = {1'b0, block_pt};
            pt_byte.last = 1'b0;
            payload_q.push_back(pt_byte);
            // E is set on every block but the newest.
            for (int i = 0; i < n; i++)
                push_word({events[i].code, i < n - 1, 1'b0, events[i].volume,
                           events[i].duration}, i == n - 1);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        payload_byte_t want;
        if (!rst_n)
        begin
            payload_q.delete();
            n_events  = 0;
            redundant = 1'b0;
            block_pt  = '0;
        end
        else
        begin
            if (out_tvalid && out_tready)
            begin
                if (payload_q.size() == 0)
                begin
                    $error("out_tdata: unexpected transfer, got %0h", out_tdata);
                    err_cnt++;
                end
                else
                begin
                    want = payload_q.pop_front();
                    if (out_tdata !== want.data)
                    begin
                        $error("out_byte: expected %0h, got %0h", want.data, out_tdata);
                        err_cnt++;
                    end
                    if (out_tlast !== want.last)
                    begin
                        $error("last_byte: expected %0b, got %0b", want.last, out_tlast);
                        err_cnt++;
                    end
                end
            end
            if (in_tvalid && in_tready)
                encode_event(in_tdata);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MODE)
                    redundant = cfg_data[0];
                else if (cfg_index == REG_PT)
                    block_pt = cfg_data[6:0];
            end
        end
        mismatches  <= err_cnt;
        outstanding <= payload_q.size();
    end

endmodule

[dv/tb.sv]
// Testbench top: clock, reset, event and register stimulus, receiver stalls, verdict.
`timescale 1ns / 100ps

module tb;
    import dtmfenc_pkg::*;

    localparam int EVENT_COUNT = 205;
    localparam int PHASES      = 6;
    localparam int LIMIT       = 1_000_000;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_tvalid  = 1'b0;
    logic        in_tready;
    logic [63:0] in_tdata   = '0;
    logic        out_tvalid;
    logic        out_tready = 1'b0;
    logic [7:0]  out_tdata;
    logic        out_tlast;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index  = '0;
    logic [7:0]  cfg_data   = '0;

    int          mismatches;
    int          outstanding;
    int          cycle_count = 0;
    int          burst_left  = 0;
    logic        steady      = 1'b0;
    logic [31:0] stamp_base  = '0;

    // receiver stall pattern
    int          stall_style = 0;
    int          style_left  = 0;
    int          stall_hold  = 0;
    int          tick        = 0;

    dtmf_event_payload_encoder #(.HISTORY_DEPTH(3)) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_tvalid  (in_tvalid),
        .in_tready  (in_tready),
        .in_tdata   (in_tdata),
        .out_tvalid (out_tvalid),
        .out_tready (out_tready),
        .out_tdata  (out_tdata),
        .out_tlast  (out_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    dtmf_payload_checker #(.DEPTH(3)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_tvalid   (in_tvalid),
        .in_tready   (in_tready),
        .in_tdata    (in_tdata),
        .out_tvalid  (out_tvalid),
        .out_tready  (out_tready),
        .out_tdata   (out_tdata),
        .out_tlast   (out_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("dtmf_event_payload_encoder regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (style_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(20, 120);
        end
        else
            style_left--;
        tick++;
        case (stall_style)
            0: out_tready <= 1'b1;
            1: out_tready <= 1'($urandom_range(0, 1));
            2: out_tready <= (tick % 4 != 0);
            default:
            begin
                if (stall_hold > 0)
                begin
                    stall_hold--;
                    out_tready <= 1'b0;
                end
                else
                begin
                    if ($urandom_range(0, 7) == 0)
                        stall_hold = $urandom_range(5, 30);
                    out_tready <= 1'b1;
                end
            end
        endcase
    end

    function automatic logic [63:0] pack_event(input logic [7:0] key, input logic end_bit,
                                               input logic [5:0] vol, input logic [15:0] dur,
                                               input logic [31:0] ts);
        return {1'b0, ts, dur, vol, end_bit, key};
    endfunction

    // 0..9 digits, then star, hash, upper A-D, lower a-d
    function automatic logic [7:0] dtmf_key(input int idx);
        case (idx)
            10:      return KEY_STAR;
            11:      return KEY_HASH;
            12:      return KEY_UP_A;
            13:      return KEY_UP_B;
            14:      return KEY_UP_C;
            15:      return KEY_UP_D;
            16:      return KEY_LO_A;
            17:      return KEY_LO_B;
            18:      return KEY_LO_C;
            19:      return KEY_LO_D;
            default: return KEY_0 + 8'(idx);
        endcase
    endfunction

    function automatic logic [7:0] sweep_key(input int j);
        case (j)
            0:       return KEY_0;
            1:       return KEY_9;
            14:      return 8'h00;
            15:      return 8'hFF;
            16:      return KEY_0 - 8'd1;
            17:      return KEY_9 + 8'd1;
            default: return dtmf_key(j + 8);
        endcase
    endfunction

    function automatic logic [63:0] random_event();
        logic [7:0]  key;
        logic [31:0] ts;
        if ($urandom_range(0, 9) < 8)
            key = dtmf_key($urandom_range(0, 19));
        else
            key = 8'($urandom_range(0, 255));
        // mostly a steadily advancing clock, sometimes an arbitrary jump
        if ($urandom_range(0, 5) == 0)
            stamp_base = $urandom;
        else
            stamp_base = stamp_base + $urandom_range(0, 2000);
        ts = stamp_base;
        return pack_event(key, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                          16'($urandom_range(0, 65535)), ts);
    endfunction

    task automatic send_event(input logic [63:0] ev);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_tvalid <= 1'b1;
        in_tdata  <= ev;
        do @(posedge clk); while (!in_tready);
    endtask

    // Holds the sender until every predicted byte has been seen.
    task automatic wait_drained();
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic mode, input logic [6:0] pt);
        cfg_valid <= 1'b1;
        cfg_index <= REG_MODE;
        cfg_data  <= {7'd0, mode};
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= REG_PT;
        cfg_data  <= {1'b0, pt};
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic       mode;
        logic [6:0] pt;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Redundant from reset so the history grows through one, two, three entries;
        // the stamps wrap so the offsets exceed 14 bits.
        set_config(1'b1, 7'd127);
        send_event(pack_event(KEY_0 + 8'd5, 1'b1, 6'd63, 16'hFFFF, 32'h0000_0000));
        send_event(pack_event(KEY_HASH, 1'b0, 6'd0, 16'h0000, 32'hFFFF_FFFF));
        send_event(pack_event(KEY_STAR, 1'b1, 6'd21, 16'h1234, 32'h0000_4001));
        wait_drained();

        // plain mode: keys 0 and 9, star, hash, A-D, a-d, unknown keys, field extremes
        set_config(1'b0, 7'd0);
        for (int j = 0; j < 18; j++)
            send_event(pack_event(sweep_key(j), j[0], j[0] ? 6'd63 : 6'd0,
                                  j[1] ? 16'hFFFF : 16'h0000,
                                  j[0] ? 32'hFFFF_FFFF : 32'h0000_0000));
        wait_drained();

        // unknown keys kept in the redundant history; end bit ignored there
        set_config(1'b1, 7'd0);
        send_event(pack_event(8'hFF, 1'b1, 6'd63, 16'hFFFF, 32'h8000_0000));
        send_event(pack_event(8'h00, 1'b1, 6'd0, 16'h0001, 32'h7FFF_C000));
        wait_drained();

        stamp_base = $urandom;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin mode = 1'b1; pt = 7'd0;   end
                1:       begin mode = 1'b0; pt = 7'd127; end
                2:       begin mode = 1'b1; pt = 7'd127; end
                3:       begin mode = 1'b0; pt = 7'($urandom_range(0, 127)); end
                default: begin mode = 1'b1; pt = 7'($urandom_range(0, 127)); end
            endcase
            set_config(mode, pt);
            steady     = (p == 2);
            burst_left = 0;
            for (int k = 0; k < EVENT_COUNT / PHASES + 1; k++)
            begin
                if ($urandom_range(0, 24) == 0)
                    wait_drained();
                send_event(random_event());
            end
            wait_drained();
        end

        repeat (30) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("dtmf_event_payload_encoder regression: pass");
        else
            $display("dtmf_event_payload_encoder regression: fail");
        $finish;
    end

endmodule
